// ----- sv/dtsc_pkg.sv -----
`timescale 1ns / 1ps

package dtsc_pkg;

    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned FIFO_DEPTH = 8;
    localparam int unsigned FIFO_AW    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PRECISION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(1);

    localparam logic [15:0] PRECISION_RESET = 16'd10;
    localparam logic [7:0]  WINDOW_RESET    = 8'd30;

    localparam logic signed [15:0] EXT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] EXT_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } axis_t;

    typedef struct packed {
        logic signed [15:0] sample_x;
        logic signed [15:0] sample_y;
        logic signed [15:0] sample_z;
    } in_t;

    typedef struct packed {
        logic [7:0] step_count;
        logic [1:0] motion_axis;
    } out_t;

    typedef struct packed {
        logic acc;
        logic last;
        logic peak_en;
        logic wstart;
    } lane_ctrl_t;

    typedef struct packed {
        logic signed [15:0] avg;
        logic signed [15:0] thr;
        logic signed [16:0] span;
    } lane_res_t;

    typedef struct packed {
        logic valid;
        logic wend;
    } merge_ctrl_t;

endpackage

// ----- sv/dtsc_lane.sv -----
`timescale 1ns / 1ps

module dtsc_lane #(
    parameter int unsigned AVG_COUNT = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dtsc_pkg::lane_ctrl_t  ctrl,
    input  logic signed [15:0]    sample,
    output dtsc_pkg::lane_res_t   res
);
    import dtsc_pkg::*;

    localparam int unsigned SUM_W  = 16 + $clog2(AVG_COUNT);
    localparam int unsigned SHIFT  = SUM_W + 5;
    localparam int unsigned MULT_W = SHIFT + 1;
    localparam int unsigned PROD_W = SUM_W + MULT_W;
    localparam longint unsigned MULT_L =
        ((64'd1 << SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT);
    localparam logic [MULT_W-1:0] MULT = MULT_W'(MULT_L);

    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  total_reg;
    logic [SUM_W-1:0]         mag;
    logic [PROD_W-1:0]        prod_reg;
    logic                     neg_reg;
    logic [16:0]              quo;
    logic signed [17:0]       quo_s;
    logic signed [15:0]       avg_reg;
    logic signed [15:0]       avg4_reg;
    logic signed [15:0]       max_reg;
    logic signed [15:0]       min_reg;
    logic signed [15:0]       base_max;
    logic signed [15:0]       base_min;
    logic signed [15:0]       max_next;
    logic signed [15:0]       min_next;
    logic signed [16:0]       pair_sum;
    logic signed [16:0]       pair_adj;
    lane_res_t                res_reg;
    lane_res_t                res_next;

    // accumulate
    assign sum_next = sum_reg + SUM_W'(sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (ctrl.acc) begin
            sum_reg <= ctrl.last ? '0 : sum_next;
        end
    end

    // divide by AVG_COUNT: reciprocal multiply on the magnitude, exact for this range
    always_comb begin
        mag   = total_reg[SUM_W-1] ? SUM_W'(-total_reg) : SUM_W'(total_reg);
        quo   = prod_reg[SHIFT +: 17];
        quo_s = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end

    // peak tracking
    always_comb begin
        base_max = ctrl.wstart ? EXT_MIN : max_reg;
        base_min = ctrl.wstart ? EXT_MAX : min_reg;
        max_next = (avg_reg > base_max) ? avg_reg : base_max;
        min_next = (avg_reg < base_min) ? avg_reg : base_min;
    end

    // span and midpoint, midpoint truncated toward zero
    always_comb begin
        pair_sum      = 17'(max_reg) + 17'(min_reg);
        pair_adj      = pair_sum + $signed({16'b0, pair_sum[16] & pair_sum[0]});
        res_next.avg  = avg4_reg;
        res_next.thr  = pair_adj[16:1];
        res_next.span = 17'(max_reg) - 17'(min_reg);
    end

    always_ff @(posedge aclk) begin
        total_reg <= sum_next;
        prod_reg  <= PROD_W'(mag) * PROD_W'(MULT);
        neg_reg   <= total_reg[SUM_W-1];
        avg_reg   <= quo_s[15:0];
        avg4_reg  <= avg_reg;
        res_reg   <= res_next;
        if (ctrl.peak_en) begin
            max_reg <= max_next;
            min_reg <= min_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- sv/dtsc_merge.sv -----
`timescale 1ns / 1ps

module dtsc_merge (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dtsc_pkg::merge_ctrl_t ctrl,
    input  dtsc_pkg::lane_res_t   lanes [dtsc_pkg::NUM_AXES],
    input  logic [15:0]           precision,
    output logic                  wr_valid,
    output dtsc_pkg::out_t        wr_data
);
    import dtsc_pkg::*;

    axis_t              axis_reg;
    axis_t              axis_next;
    axis_t              pick;
    logic [7:0]         steps_reg;
    logic [7:0]         steps_next;
    logic signed [15:0] newer_reg  [NUM_AXES];
    logic signed [15:0] newer_next [NUM_AXES];
    logic signed [16:0] diff       [NUM_AXES];
    logic [16:0]        dmag       [NUM_AXES];
    logic [NUM_AXES-1:0] hit;
    logic [NUM_AXES-1:0] upd;

    // most active axis, ties toward the later axis
    always_comb begin
        if (lanes[0].span > lanes[1].span) begin
            pick = (lanes[0].span > lanes[2].span) ? AXIS_X : AXIS_Z;
        end else begin
            pick = (lanes[1].span > lanes[2].span) ? AXIS_Y : AXIS_Z;
        end
        axis_next = ctrl.wend ? pick : axis_reg;
    end

    // slide register and crossing check on every lane, applied on the active one
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            diff[k]       = 17'(lanes[k].avg) - 17'(newer_reg[k]);
            dmag[k]       = diff[k][16] ? 17'(-diff[k]) : 17'(diff[k]);
            newer_next[k] = (dmag[k] > {1'b0, precision}) ? lanes[k].avg : newer_reg[k];
            hit[k]        = (newer_reg[k] > lanes[k].thr) && (newer_next[k] < lanes[k].thr);
            upd[k]        = ctrl.valid && (axis_next == axis_t'(2'(k + 1)));
        end
        steps_next = steps_reg + 8'(|(upd & hit));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg  <= AXIS_NONE;
            steps_reg <= '0;
            for (int k = 0; k < NUM_AXES; k++) begin
                newer_reg[k] <= '0;
            end
        end else if (ctrl.valid) begin
            axis_reg  <= axis_next;
            steps_reg <= steps_next;
            for (int k = 0; k < NUM_AXES; k++) begin
                if (upd[k]) begin
                    newer_reg[k] <= newer_next[k];
                end
            end
        end
    end

    always_comb begin
        wr_valid            = ctrl.valid;
        wr_data.step_count  = steps_next;
        wr_data.motion_axis = axis_next;
    end

    a_axis_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (axis_reg != AXIS_NONE) |=> (axis_reg != AXIS_NONE))
        else $error("active axis fell back to none");

    a_steps_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.valid |=> $stable(steps_reg))
        else $error("step count moved without an averaged sample");

endmodule

// ----- sv/dtsc_fifo.sv -----
`timescale 1ns / 1ps

module dtsc_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    input  dtsc_pkg::out_t  wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output dtsc_pkg::out_t  rd_data
);
    import dtsc_pkg::*;

    out_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               pop;

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_valid) begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (FIFO_AW + 1)'(wr_valid) - (FIFO_AW + 1)'(pop);
        end
    end

endmodule

// ----- sv/dynamic_threshold_step_counter_core.sv -----
// A completed average passes through the lane stages and the merge, and its write into the result queue raises m_valid.
// Throughput: one sample per cycle while s_ready is high; one result per AVG_COUNT samples.
// Each axis lane runs sum, reciprocal divide, peak track and midpoint in 5 stages.
// An 8-entry result queue with occupancy credit holds s_ready low while all 8 entries are reserved.
// Reset (aresetn low, synchronous) clears sums, window, axis, slide values and step count.
`timescale 1ns / 1ps

module dynamic_threshold_step_counter_core #(
    parameter int unsigned AVG_COUNT = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dtsc_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output dtsc_pkg::out_t                     m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dtsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data
);
    import dtsc_pkg::*;

    localparam int unsigned FILL_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
    localparam int unsigned OCC_W  = $clog2(FIFO_DEPTH + 1);

    logic [FILL_W-1:0] fill_reg;
    logic [7:0]        win_reg;
    logic [7:0]        win_inc;
    logic [15:0]       prec_reg;
    logic [7:0]        wlen_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic              acc;
    logic              last;
    logic              wstart;
    logic              wend;
    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic              wend4_reg, wend5_reg;
    logic              wr_valid;
    out_t              wr_data;
    lane_ctrl_t        lane_ctrl;
    merge_ctrl_t       merge_ctrl;
    lane_res_t         lane_res [NUM_AXES];
    logic signed [15:0] samples [NUM_AXES];

    assign s_ready   = (occ_reg < OCC_W'(FIFO_DEPTH));
    assign cfg_ready = 1'b1;
    assign acc       = s_valid && s_ready;
    assign last      = (fill_reg == FILL_W'(AVG_COUNT - 1));
    assign wstart    = (win_reg == '0);
    assign win_inc   = win_reg + 8'd1;
    assign wend      = (win_inc == wlen_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prec_reg <= PRECISION_RESET;
            wlen_reg <= WINDOW_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PRECISION: prec_reg <= cfg_data;
                REG_WINDOW:    wlen_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            win_reg   <= '0;
            occ_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            wend4_reg <= 1'b0;
            wend5_reg <= 1'b0;
        end else begin
            if (acc) begin
                fill_reg <= last ? '0 : fill_reg + 1'b1;
            end
            if (v3_reg) begin
                win_reg <= wend ? 8'd0 : win_inc;
            end
            occ_reg   <= occ_reg + OCC_W'(acc && last) - OCC_W'(m_valid && m_ready);
            v1_reg    <= acc && last;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            wend4_reg <= v3_reg && wend;
            wend5_reg <= wend4_reg;
        end
    end

    always_comb begin
        lane_ctrl.acc     = acc;
        lane_ctrl.last    = last;
        lane_ctrl.peak_en = v3_reg;
        lane_ctrl.wstart  = wstart;
        merge_ctrl.valid  = v5_reg;
        merge_ctrl.wend   = wend5_reg;
        samples[0]        = s_data.sample_x;
        samples[1]        = s_data.sample_y;
        samples[2]        = s_data.sample_z;
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        dtsc_lane #(
            .AVG_COUNT (AVG_COUNT)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .sample  (samples[g]),
            .res     (lane_res[g])
        );
    end

    dtsc_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (merge_ctrl),
        .lanes     (lane_res),
        .precision (prec_reg),
        .wr_valid  (wr_valid),
        .wr_data   (wr_data)
    );

    dtsc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (wr_valid),
        .wr_data  (wr_data),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (m_data)
    );

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(FIFO_DEPTH))
        else $error("result occupancy exceeds queue depth");

    a_occ_covers_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_valid |-> (occ_reg != '0))
        else $error("result written without reserved queue space");

    a_window_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && wend) |=> (win_reg == '0))
        else $error("window counter did not restart at window end");

endmodule
